/* hw/rtl/natt_pkg.sv */
package natt_pkg;

  // command codes
  localparam logic [1:0] CMD_INC   = 2'd0;
  localparam logic [1:0] CMD_DEL   = 2'd1;
  localparam logic [1:0] CMD_QUERY = 2'd2;
  localparam logic [1:0] CMD_LIST  = 2'd3;

  // status codes
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  localparam logic [31:0] TICK_MAX = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] neighbor_addr;
  } natt_in_t;

  typedef struct packed {
    logic        found;
    logic [31:0] tick;
    logic [31:0] entry_addr;
    logic        status;
    logic        last;
  } natt_out_t;

endpackage

/* hw/rtl/natt_ram.sv */
module natt_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                      wr_data,
  input  logic                                  rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                      rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // single write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* hw/rtl/neighbor_assoc_tick_table.sv */
// An increase, delete or query beat taken at start gives one result after the slot scan.
// List results come out during the slot scan, the final one (last set) after it.
// A new beat is taken only while idle (busy low): the slot memory is scanned through
// its one read port, one slot a cycle, then a finish step writes back and answers.
// Reset: synchronous active-low rst_n empties the table; no clearing pass is needed.
// The receiver cannot stall: each result is shown for one cycle on out_strobe.
module neighbor_assoc_tick_table #(
  parameter int TABLE_ENTRIES = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  natt_pkg::natt_in_t  in_data,
  output logic                out_strobe,
  output natt_pkg::natt_out_t out_data
);
  import natt_pkg::*;

  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CW = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CW-1:0] CNT_END  = CW'(TABLE_ENTRIES);
  localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_ENTRIES - 1);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  logic [1:0]               state_r;
  logic [1:0]               cmd_r;
  logic [31:0]              addr_r;
  logic [CW-1:0]            issue_cnt_r;
  logic                     chk_vld_r;
  logic [IW-1:0]            chk_idx_r;
  logic [TABLE_ENTRIES-1:0] valid_r;
  logic                     hit_r;
  logic [IW-1:0]            hit_idx_r;
  logic [31:0]              hit_tick_r;
  logic                     free_vld_r;
  logic [IW-1:0]            free_idx_r;
  logic                     pend_vld_r;
  logic [31:0]              pend_tick_r;
  logic [31:0]              pend_addr_r;
  logic                     out_strobe_r;
  logic                     out_strobe_nxt;
  natt_out_t                out_r;

  logic              rd_en;
  logic [63:0]       rd_data;
  logic              wr_en;
  logic [IW-1:0]     wr_addr;
  logic [63:0]       wr_data;
  logic              slot_vld;
  logic              slot_hit;
  logic [31:0]       slot_addr;
  logic [31:0]       slot_tick;
  logic [31:0]       tick_inc;

  // slot memory: address in the upper half, tick in the lower
  natt_ram #(
    .WIDTH (64),
    .DEPTH (TABLE_ENTRIES)
  ) u_slot_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (issue_cnt_r[IW-1:0]),
    .rd_data (rd_data)
  );

  // scan compare on the slot returned by the memory
  assign slot_addr = rd_data[63:32];
  assign slot_tick = rd_data[31:0];
  assign slot_vld  = valid_r[chk_idx_r];
  assign slot_hit  = slot_vld && (slot_addr == addr_r);
  assign rd_en     = (state_r == ST_SCAN) && (issue_cnt_r < CNT_END);

  // saturating tick increment
  assign tick_inc = (hit_tick_r == TICK_MAX) ? hit_tick_r : hit_tick_r + 32'd1;

  // write back only for increase, after the scan has ended
  assign wr_en   = (state_r == ST_FINISH) && (cmd_r == CMD_INC) && (hit_r || free_vld_r);
  assign wr_addr = hit_r ? hit_idx_r : free_idx_r;
  assign wr_data = {addr_r, (hit_r ? tick_inc : 32'd1)};

  // a beat goes out at the end of every command and for each held list entry
  assign out_strobe_nxt = (state_r == ST_FINISH) ||
                          ((state_r == ST_SCAN) && chk_vld_r && (cmd_r == CMD_LIST) &&
                           slot_vld && pend_vld_r);

  assign busy       = (state_r != ST_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_data   = out_r;

  // result strobe and read return flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
      chk_vld_r    <= 1'b0;
    end else begin
      out_strobe_r <= out_strobe_nxt;
      chk_vld_r    <= rd_en;
    end
  end

  // sequencer: accept, scan, finish
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      valid_r      <= '0;
      hit_r        <= 1'b0;
      free_vld_r   <= 1'b0;
      pend_vld_r   <= 1'b0;
      issue_cnt_r  <= '0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (start) begin
            cmd_r       <= in_data.command;
            addr_r      <= in_data.neighbor_addr;
            issue_cnt_r <= '0;
            hit_r       <= 1'b0;
            free_vld_r  <= 1'b0;
            pend_vld_r  <= 1'b0;
            state_r     <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          // issue one slot read a cycle
          if (issue_cnt_r < CNT_END) begin
            issue_cnt_r <= issue_cnt_r + CW'(1);
            chk_idx_r   <= issue_cnt_r[IW-1:0];
          end
          // examine the slot returned by the previous read
          if (chk_vld_r) begin
            if (cmd_r == CMD_LIST) begin
              // hold one entry back so the final one can carry last
              if (slot_vld) begin
                if (pend_vld_r) begin
                  out_r.found      <= 1'b1;
                  out_r.tick       <= pend_tick_r;
                  out_r.entry_addr <= pend_addr_r;
                  out_r.status     <= STATUS_OK;
                  out_r.last       <= 1'b0;
                end
                pend_vld_r  <= 1'b1;
                pend_tick_r <= slot_tick;
                pend_addr_r <= slot_addr;
              end
            end else begin
              if (slot_hit) begin
                hit_r      <= 1'b1;
                hit_idx_r  <= chk_idx_r;
                hit_tick_r <= slot_tick;
              end
              // lowest free slot
              if (!slot_vld && !free_vld_r) begin
                free_vld_r <= 1'b1;
                free_idx_r <= chk_idx_r;
              end
            end
            if (chk_idx_r == LAST_IDX) begin
              state_r <= ST_FINISH;
            end
          end
        end
        ST_FINISH: begin
          out_r.last <= 1'b1;
          case (cmd_r)
            CMD_INC: begin
              out_r.entry_addr <= addr_r;
              if (hit_r) begin
                out_r.found  <= 1'b1;
                out_r.tick   <= tick_inc;
                out_r.status <= STATUS_OK;
              end else if (free_vld_r) begin
                out_r.found         <= 1'b0;
                out_r.tick          <= 32'd1;
                out_r.status        <= STATUS_OK;
                valid_r[free_idx_r] <= 1'b1;
              end else begin
                out_r.found  <= 1'b0;
                out_r.tick   <= '0;
                out_r.status <= STATUS_FULL;
              end
            end
            CMD_DEL: begin
              out_r.entry_addr <= addr_r;
              out_r.status     <= STATUS_OK;
              out_r.found      <= hit_r;
              out_r.tick       <= hit_r ? hit_tick_r : 32'd0;
              if (hit_r) begin
                valid_r[hit_idx_r] <= 1'b0;
              end
            end
            CMD_QUERY: begin
              out_r.entry_addr <= addr_r;
              out_r.status     <= STATUS_OK;
              out_r.found      <= hit_r;
              out_r.tick       <= hit_r ? hit_tick_r : 32'd0;
            end
            CMD_LIST: begin
              // final held entry, or the empty-table beat
              out_r.status     <= STATUS_OK;
              out_r.found      <= pend_vld_r;
              out_r.tick       <= pend_vld_r ? pend_tick_r : 32'd0;
              out_r.entry_addr <= pend_vld_r ? pend_addr_r : 32'd0;
            end
            default: begin
              out_r.entry_addr <= addr_r;
              out_r.status     <= STATUS_OK;
              out_r.found      <= 1'b0;
              out_r.tick       <= '0;
            end
          endcase
          state_r <= ST_IDLE;
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
